### hw/rtl/iwds_pkg.sv
// shared types and constants for the inverse weight delta scaler
package iwds_pkg;

  // field widths
  localparam int unsigned DeltaW = 64;
  localparam int unsigned HalfW = 32;
  localparam int unsigned FracBits = 10;
  localparam int unsigned WtW = HalfW - FracBits;
  localparam int unsigned QuoW = HalfW;
  localparam int unsigned ProdW = WtW + HalfW;
  localparam int unsigned ShW = 6;
  localparam int unsigned KW = 5;

  // divider pipeline shape
  localparam int unsigned DivBitsPerStage = 4;
  localparam int unsigned DivStages = QuoW / DivBitsPerStage;
  localparam int unsigned MulStages = 5;

  // input beat
  typedef struct packed {
    logic [DeltaW-1:0] elapsed_time;
    logic [HalfW-1:0]  task_weight;
    logic [HalfW-1:0]  total_weight;
    logic [HalfW-1:0]  given_inverse;
  } iwds_in_t;

  // result beat
  typedef struct packed {
    logic [DeltaW-1:0] scaled_delta;
    logic [HalfW-1:0]  inverse_used;
  } iwds_out_t;

  // divider hand-off to the multiply pipeline
  typedef struct packed {
    logic [DeltaW-1:0] delta;
    logic [WtW-1:0]    wt;
    logic [HalfW-1:0]  inv;
  } iwds_inv_t;

endpackage

### hw/rtl/iwds_div_pipe.sv
// pipelined restoring divider that forms the inverse of the load weight
module iwds_div_pipe
  import iwds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  iwds_in_t  in_i,
  output logic      valid_o,
  output iwds_inv_t res_o
);

  // per-stage divider state
  typedef struct packed {
    logic [DeltaW-1:0] delta;
    logic [WtW-1:0]    wt;
    logic [WtW-1:0]    dv;
    logic [HalfW-1:0]  given;
    logic [WtW-1:0]    rem;
    logic [QuoW-1:0]   quo;
  } iwds_div_t;

  iwds_div_t               stage_in;
  iwds_div_t               stg_d [DivStages];
  iwds_div_t               stg_q [DivStages];
  logic [DivStages-1:0]    vld_q;
  logic [DivStages-1:0]    vld_d;
  iwds_div_t               last;

  // several quotient bits of all-ones / dv; the dividend shifts in ones
  function automatic iwds_div_t div_steps(iwds_div_t cur);
    iwds_div_t      nxt;
    logic [WtW:0]   t;
    nxt = cur;
    for (int b = 0; b < DivBitsPerStage; b++) begin
      t = {nxt.rem, 1'b1};
      if (t >= {1'b0, nxt.dv}) begin
        t = t - {1'b0, nxt.dv};
        nxt.rem = t[WtW-1:0];
        nxt.quo = {nxt.quo[QuoW-2:0], 1'b1};
      end else begin
        nxt.rem = t[WtW-1:0];
        nxt.quo = {nxt.quo[QuoW-2:0], 1'b0};
      end
    end
    return nxt;
  endfunction

  // stage entry
  always_comb begin
    stage_in.delta = in_i.elapsed_time;
    stage_in.wt    = in_i.task_weight[HalfW-1:FracBits];
    stage_in.dv    = in_i.total_weight[HalfW-1:FracBits];
    stage_in.given = in_i.given_inverse;
    stage_in.rem   = '0;
    stage_in.quo   = '0;
  end

  // next value of each stage
  always_comb begin
    stg_d[0] = div_steps(stage_in);
    vld_d[0] = valid_i;
    for (int s = 1; s < DivStages; s++) begin
      stg_d[s] = div_steps(stg_q[s-1]);
      vld_d[s] = vld_q[s-1];
    end
  end

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // stage payload
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < DivStages; s++) begin
      stg_q[s] <= stg_d[s];
    end
  end

  // pick the inverse: given, saturated on zero divisor, or the quotient
  assign last    = stg_q[DivStages-1];
  assign valid_o = vld_q[DivStages-1];

  always_comb begin
    res_o.delta = last.delta;
    res_o.wt    = last.wt;
    if (last.given != '0) begin
      res_o.inv = last.given;
    end else if (last.dv == '0) begin
      res_o.inv = '1;
    end else begin
      res_o.inv = last.quo;
    end
  end

`ifndef SYNTHESIS
  // a finished division leaves a remainder below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && last.dv != '0) |-> (last.rem < last.dv))
    else $error("divider remainder not below divisor");

  // every beat leaving the divider entered it a fixed number of cycles before
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(valid_i, DivStages))
    else $error("divider output without matching input");
`endif

endmodule

### hw/rtl/iwds_mul_pipe.sv
// factor product, normalization, partial products and final sum
module iwds_mul_pipe
  import iwds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      valid_i,
  input  iwds_inv_t in_i,
  output logic      valid_o,
  output iwds_out_t res_o
);

  logic [MulStages-1:0] vld_q;

  // stage 1 registers
  logic [ProdW-1:0]  prod_q;
  logic [DeltaW-1:0] delta1_q;
  logic [HalfW-1:0]  inv1_q;

  // stage 2 registers
  logic [HalfW-1:0]  fn_q;
  logic [HalfW-1:0]  fn_d;
  logic [ShW-1:0]    sh_q;
  logic [ShW-1:0]    sh_d;
  logic [KW-1:0]     k;
  logic [DeltaW-1:0] delta2_q;
  logic [HalfW-1:0]  inv2_q;

  // stage 3 registers
  logic [DeltaW-1:0] plo_q;
  logic [DeltaW-1:0] phi_q;
  logic [ShW-1:0]    sh3_q;
  logic [HalfW-1:0]  inv3_q;

  // stage 4 registers
  logic [DeltaW-1:0] a_q;
  logic [DeltaW-1:0] b_q;
  logic [HalfW-1:0]  inv4_q;

  // stage 5 registers
  iwds_out_t         out_q;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[MulStages-2:0], valid_i};
    end
  end

  // normalize: drop as many low bits as the high half is long
  always_comb begin
    k = '0;
    for (int i = 0; i < WtW; i++) begin
      if (prod_q[HalfW+i]) begin
        k = KW'(i + 1);
      end
    end
    fn_d = HalfW'(prod_q >> k);
    sh_d = ShW'(HalfW) - {1'b0, k};
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    // weight times inverse
    prod_q   <= ProdW'(in_i.wt * in_i.inv);
    delta1_q <= in_i.delta;
    inv1_q   <= in_i.inv;
    // normalized factor and shift
    fn_q     <= fn_d;
    sh_q     <= sh_d;
    delta2_q <= delta1_q;
    inv2_q   <= inv1_q;
    // partial products of both delta halves
    plo_q    <= DeltaW'(delta2_q[HalfW-1:0] * fn_q);
    phi_q    <= DeltaW'(delta2_q[DeltaW-1:HalfW] * fn_q);
    sh3_q    <= sh_q;
    inv3_q   <= inv2_q;
    // align the partial products
    a_q      <= plo_q >> sh3_q;
    b_q      <= phi_q << (ShW'(HalfW) - sh3_q);
    inv4_q   <= inv3_q;
    // wrapping sum
    out_q.scaled_delta <= a_q + b_q;
    out_q.inverse_used <= inv4_q;
  end

  assign valid_o = vld_q[MulStages-1];
  assign res_o   = out_q;

`ifndef SYNTHESIS
  // shift count stays in the range the weight width allows
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] |-> (sh_q >= ShW'(FracBits) && sh_q <= ShW'(HalfW)))
    else $error("shift count out of range");

  // a factor that was shifted keeps its top bit set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[1] && sh_q != ShW'(HalfW)) |-> fn_q[HalfW-1])
    else $error("factor not normalized");
`endif

endmodule

### hw/rtl/inverse_weight_delta_scaler.sv
// top level of the inverse weight delta scaler
// Scales elapsed_time by task_weight / total_weight with a reciprocal multiply.
// One beat is taken in every cycle and busy never rises; each result leaves
// in order, marked by valid_o for one cycle. The path is 8 stages of the
// inverse divider (4 quotient bits per stage) plus 5 stages of factor
// multiply, normalize, delta multiplies, alignment shift and final 64-bit
// add. A nonzero given_inverse is used as is; a zero one is replaced by
// all-ones / (total_weight >> 10), or all-ones when that divisor is zero.
// The output has no back-pressure and must be taken when valid_o is high.
module inverse_weight_delta_scaler
  import iwds_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  input  iwds_in_t  in_i,
  output logic      busy,
  output logic      valid_o,
  output iwds_out_t result_o
);

  logic      div_vld;
  iwds_inv_t div_res;

  // the pipeline takes a beat every cycle
  assign busy = 1'b0;

  // inverse of the load weight
  iwds_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .in_i    (in_i),
    .valid_o (div_vld),
    .res_o   (div_res)
  );

  // factor and scaled delta
  iwds_mul_pipe u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (div_vld),
    .in_i    (div_res),
    .valid_o (valid_o),
    .res_o   (result_o)
  );

`ifndef SYNTHESIS
  // the inverse applied is never zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (result_o.inverse_used != '0))
    else $error("zero inverse on result");
`endif

endmodule

### verif/tb.sv
// self-checking testbench for the inverse weight delta scaler
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import iwds_pkg::*;

  localparam int unsigned HalfClk = 6;
  localparam int unsigned RandomBeats = 500;
  localparam int unsigned IdlePct = 19;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned CycleLimit = 60000;

  // expected scaled deltas, predicted from accepted beats
  class scaled_delta_board;
    iwds_out_t   pending_scaled[$];
    int unsigned mismatch_count;
    int unsigned beats_noted;
    int unsigned results_checked;
    int unsigned computed_inverses;

    // reciprocal-multiply scaling of one beat
    function iwds_out_t predict_scaled(iwds_in_t b);
      logic [HalfW-1:0]  divisor;
      logic [DeltaW-1:0] wt_wide, inv_wide, factor, lo_wide, hi_wide, sum;
      int unsigned       shift;
      iwds_out_t         r;
      // inverse: given one wins, else all-ones over the integer load weight
      if (b.given_inverse != '0) begin
        r.inverse_used = b.given_inverse;
      end else begin
        divisor = b.total_weight >> FracBits;
        if (divisor == '0) begin
          r.inverse_used = '1;
        end else begin
          r.inverse_used = {HalfW{1'b1}} / divisor;
        end
      end
      // factor normalized into 32 bits, shift count drops from 32
      wt_wide  = DeltaW'(b.task_weight >> FracBits);
      inv_wide = DeltaW'(r.inverse_used);
      factor   = wt_wide * inv_wide;
      shift    = HalfW;
      while (factor[DeltaW-1:HalfW] != '0 && shift > 0) begin
        factor = factor >> 1;
        shift--;
      end
      // low and high partial products, wrapping at 64 bits
      lo_wide = DeltaW'(b.elapsed_time[HalfW-1:0]);
      hi_wide = DeltaW'(b.elapsed_time[DeltaW-1:HalfW]);
      sum = (lo_wide * factor) >> shift;
      if (hi_wide != '0) begin
        sum = sum + ((hi_wide * factor) << (HalfW - shift));
      end
      r.scaled_delta = sum;
      return r;
    endfunction

    function void note_beat(iwds_in_t b);
      pending_scaled.push_back(predict_scaled(b));
      beats_noted++;
      if (b.given_inverse == '0) begin
        computed_inverses++;
      end
    endfunction

    task report_mismatch(string what);
      $display("ERROR @%0t: %s", $realtime, what);
      mismatch_count++;
    endtask

    task check_result(iwds_out_t got);
      iwds_out_t want;
      if (pending_scaled.size() == 0) begin
        report_mismatch($sformatf("unexpected result beat %h", got));
      end else begin
        want = pending_scaled.pop_front();
        results_checked++;
        if (got.scaled_delta !== want.scaled_delta) begin
          report_mismatch($sformatf("scaled_delta %h, expected %h",
                                    got.scaled_delta, want.scaled_delta));
        end
        if (got.inverse_used !== want.inverse_used) begin
          report_mismatch($sformatf("inverse_used %h, expected %h",
                                    got.inverse_used, want.inverse_used));
        end
      end
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  iwds_in_t  in_i;
  logic      busy;
  logic      valid_o;
  iwds_out_t result_o;

  scaled_delta_board board = new();
  int unsigned       cycle_count;
  int unsigned       directed_beats;

  inverse_weight_delta_scaler u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .in_i    (in_i),
    .busy    (busy),
    .valid_o (valid_o),
    .result_o(result_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(HalfClk) clk_i = ~clk_i;
  end

  // watch accepted beats and results, enforce the cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (rst_ni) begin
      if (start && !busy) begin
        board.note_beat(in_i);
      end
      if (valid_o) begin
        board.check_result(result_o);
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // random word biased toward small values and all-ones
  function automatic logic [HalfW-1:0] pick_word();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return $urandom >> $urandom_range(0, 31);
      2: return $urandom_range(0, 2047);
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // one beat, with an occasional idle gap in front of it
  task automatic send_beat(iwds_in_t b, bit gaps_on);
    // each cycle idles with the same small chance
    while (gaps_on && $urandom_range(0, 99) < IdlePct) begin
      @(negedge clk_i);
      start <= 1'b0;
      in_i  <= {$urandom, $urandom, $urandom, $urandom, $urandom};
    end
    @(negedge clk_i);
    start <= 1'b1;
    in_i  <= b;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic send_fields(logic [DeltaW-1:0] delta, logic [HalfW-1:0] wt,
                             logic [HalfW-1:0] load, logic [HalfW-1:0] given);
    iwds_in_t b;
    b.elapsed_time  = delta;
    b.task_weight   = wt;
    b.total_weight  = load;
    b.given_inverse = given;
    send_beat(b, 1'b1);
    directed_beats++;
  endtask

  initial begin
    iwds_in_t b;
    bit       gaps_on;
    start  = 1'b0;
    in_i   = '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes and the special cases
    send_fields('0, '0, '0, '0);
    send_fields('1, '1, '1, '1);
    send_fields('1, '1, '0, '0);                     // zero divisor, max weight
    send_fields(64'h1234_5678_9abc_def0, 32'd2048, 32'd1023, '0); // divisor rounds to zero
    send_fields('1, 32'd1024, 32'd1024, '0);         // divisor of one
    send_fields('1, 32'd1023, 32'd4096, '0);         // weight below one unit
    send_fields(64'h0000_0000_ffff_ffff, '1, '1, '0); // zero high half
    send_fields(64'hffff_ffff_0000_0000, '1, 32'd1024, '0); // zero low half
    send_fields(64'd1000000, 32'd1024, '1, 32'd1);   // given inverse of one
    send_fields(64'd1000000, 32'd1024, '0, '1);      // given inverse ignores load
    send_fields('1, '1, 32'd5, 32'h8000_0000);
    send_fields(64'h8000_0000_0000_0000, 32'h8000_0000, 32'h0001_0000, '0);
    send_fields(64'd1, 32'd1024, 32'd1024, '0);
    send_fields(64'h0000_0001_0000_0000, 32'd1024, 32'd2048, '0);
    send_fields(64'haaaa_aaaa_5555_5555, 32'h5555_5555, 32'haaaa_aaaa, '0);
    send_fields(64'h5555_5555_aaaa_aaaa, 32'haaaa_aaaa, 32'h5555_5555, 32'h5555_5555);
    send_fields('1, 32'd3072, 32'd3072, '0);
    send_fields(64'hdead_beef_cafe_f00d, 32'd1048576, 32'd4194304, '0);

    // random beats, with an unbroken stretch in the middle
    for (int i = 0; i < RandomBeats; i++) begin
      gaps_on = !(i >= 150 && i < 300);
      b.elapsed_time[HalfW-1:0]      = pick_word();
      b.elapsed_time[DeltaW-1:HalfW] = ($urandom_range(0, 2) == 0) ? '0 : pick_word();
      b.task_weight   = pick_word();
      b.total_weight  = pick_word();
      b.given_inverse = ($urandom_range(0, 1) == 0) ? '0 : pick_word();
      send_beat(b, gaps_on);
    end
    @(negedge clk_i);
    start <= 1'b0;

    // drain, then let stray results show up
    while (board.pending_scaled.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d beats (%0d directed), %0d with a computed inverse",
             board.beats_noted, directed_beats, board.computed_inverses);
    $display("%0d results compared, %0d mismatches",
             board.results_checked, board.mismatch_count);
    if (board.mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
